FILE: rtl/core/wmt36_pkg.sv
package wmt36_pkg;

    // Register indexes on the configuration port.
    localparam logic [0:0] CFG_MIN_LENGTH = 1'd0;
    localparam logic [0:0] CFG_MAX_LENGTH = 1'd1;

    localparam logic [7:0] RST_MIN_LENGTH = 8'd10;
    localparam logic [7:0] RST_MAX_LENGTH = 8'd250;

    // Frame size arithmetic.
    localparam int MAX_FRAME_BYTES = 512;
    localparam int LEN_BLOCK_SPLIT = 26;
    localparam int BLOCK_BYTES     = 16;

    // Depth of the small queues between the parts of the block.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_SYMBOL = 2'd1,
        ST_BAD_LENGTH = 2'd2
    } t_status;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] coded_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] decoded_byte;
        logic [8:0] byte_index;
        logic       last_byte;
        t_status    status;
    } t_out_item;

    typedef struct packed {
        logic       ok;
        logic [3:0] nibble;
    } t_symbol;

    // One classified coded byte: one or two symbols, oldest in slot 0.
    typedef struct packed {
        logic              frame_start;
        logic              two_syms;
        t_symbol [1:0]     syms;
    } t_sym_rec;

    typedef struct packed {
        logic [7:0] min_length;
        logic [7:0] max_length;
    } t_limits;

    // Fixed 3-out-of-6 code table.
    function automatic t_symbol sym_decode(input logic [5:0] code);
        t_symbol s;
        s.ok = 1'b1;
        unique case (code)
            6'b010110: s.nibble = 4'h0;
            6'b001101: s.nibble = 4'h1;
            6'b001110: s.nibble = 4'h2;
            6'b001011: s.nibble = 4'h3;
            6'b011100: s.nibble = 4'h4;
            6'b011001: s.nibble = 4'h5;
            6'b011010: s.nibble = 4'h6;
            6'b010011: s.nibble = 4'h7;
            6'b101100: s.nibble = 4'h8;
            6'b100101: s.nibble = 4'h9;
            6'b100110: s.nibble = 4'hA;
            6'b100011: s.nibble = 4'hB;
            6'b110100: s.nibble = 4'hC;
            6'b110001: s.nibble = 4'hD;
            6'b110010: s.nibble = 4'hE;
            6'b101001: s.nibble = 4'hF;
            default: begin
                s.ok     = 1'b0;
                s.nibble = 4'h0;
            end
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/core/wmt36_fifo.sv
module wmt36_fifo
    import wmt36_pkg::*;
#(
    parameter type t_item = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               wr_en;
    logic               rd_en;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: rtl/core/wmt36_front.sv
module wmt36_front
    import wmt36_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output t_sym_rec o_rec
);

    logic [3:0]  r_left_bits;
    logic [2:0]  r_left_cnt;
    logic [3:0]  n_left_bits;
    logic [2:0]  n_left_cnt;
    logic [3:0]  cur_bits;
    logic [2:0]  cur_cnt;
    logic [11:0] bits;
    logic [5:0]  code0;
    logic [5:0]  code1;

    // A frame start restarts the symbol alignment on this byte.
    assign cur_bits = i_item.frame_start ? 4'd0 : r_left_bits;
    assign cur_cnt  = i_item.frame_start ? 3'd0 : r_left_cnt;
    assign bits     = {cur_bits, i_item.coded_byte};
    assign code1    = bits[5:0];

    always_comb begin
        o_rec.two_syms = 1'b0;
        unique case (cur_cnt)
            3'd2: begin
                code0       = bits[9:4];
                n_left_bits = bits[3:0];
                n_left_cnt  = 3'd4;
            end
            3'd4: begin
                code0          = bits[11:6];
                o_rec.two_syms = 1'b1;
                n_left_bits    = 4'd0;
                n_left_cnt     = 3'd0;
            end
            default: begin
                code0       = bits[7:2];
                n_left_bits = {2'b00, bits[1:0]};
                n_left_cnt  = 3'd2;
            end
        endcase
        o_rec.frame_start = i_item.frame_start;
        o_rec.syms[0]     = sym_decode(code0);
        o_rec.syms[1]     = sym_decode(code1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_bits <= '0;
            r_left_cnt  <= '0;
        end else if (i_accept) begin
            r_left_bits <= n_left_bits;
            r_left_cnt  <= n_left_cnt;
        end
    end

endmodule

FILE: rtl/core/wmt36_back.sv
module wmt36_back
    import wmt36_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_limits   i_limits,
    input  logic      i_rec_valid,
    input  t_sym_rec  i_rec,
    output logic      o_rec_pop,
    input  logic      i_res_full,
    output logic      o_res_push,
    output t_out_item o_result
);

    function automatic logic [8:0] frame_size_of(input logic [7:0] len);
        logic [7:0]  excess;
        logic [12:0] n;
        excess = len - 8'(LEN_BLOCK_SPLIT);
        if (len < 8'(LEN_BLOCK_SPLIT)) begin
            n = 13'(len) + 13'd5;
        end else begin
            n = 13'(len) + 13'd1 + 13'd2 * (13'(excess / BLOCK_BYTES) + 13'd3);
        end
        if (n > 13'(MAX_FRAME_BYTES)) begin
            n = 13'(MAX_FRAME_BYTES);
        end
        return n[8:0];
    endfunction

    logic       r_receiving;
    logic       r_nib_wait;
    logic [3:0] r_upper;
    logic [8:0] r_emitted;
    logic [8:0] r_frame_size;

    logic       v_rx;
    logic       v_nw;
    logic [3:0] v_up;
    logic [8:0] v_be;
    logic [8:0] v_fs;
    logic       v_stop;
    logic       v_have;
    logic [7:0] v_byte;
    logic [8:0] v_idx;
    logic       v_last;
    t_status    v_status;
    logic       fire;

    assign fire      = i_rec_valid && !i_res_full;
    assign o_rec_pop = fire;

    always_comb begin
        v_rx     = i_rec.frame_start || r_receiving;
        v_nw     = i_rec.frame_start ? 1'b0 : r_nib_wait;
        v_up     = i_rec.frame_start ? 4'd0 : r_upper;
        v_be     = i_rec.frame_start ? 9'd0 : r_emitted;
        v_fs     = i_rec.frame_start ? 9'd0 : r_frame_size;
        v_stop   = 1'b0;
        v_have   = 1'b0;
        v_byte   = 8'd0;
        v_idx    = 9'd0;
        v_last   = 1'b0;
        v_status = ST_OK;
        for (int k = 0; k < 2; k++) begin
            if ((k == 0 || i_rec.two_syms) && v_rx && !v_stop) begin
                if (!i_rec.syms[k].ok) begin
                    v_status = ST_BAD_SYMBOL;
                    v_stop   = 1'b1;
                    v_rx     = 1'b0;
                end else if (!v_nw) begin
                    v_up = i_rec.syms[k].nibble;
                    v_nw = 1'b1;
                end else begin
                    v_nw   = 1'b0;
                    v_byte = {v_up, i_rec.syms[k].nibble};
                    v_idx  = v_be;
                    v_have = 1'b1;
                    if (v_be == 9'd0) begin
                        if (v_byte < i_limits.min_length || v_byte > i_limits.max_length) begin
                            v_status = ST_BAD_LENGTH;
                            v_stop   = 1'b1;
                            v_rx     = 1'b0;
                        end else begin
                            v_fs = frame_size_of(v_byte);
                        end
                    end
                    if (!v_stop) begin
                        v_be = v_be + 9'd1;
                        if (v_be >= v_fs) begin
                            v_last = 1'b1;
                            v_rx   = 1'b0;
                            v_stop = 1'b1;
                        end
                    end
                end
            end
        end

        if (v_status != ST_OK) begin
            o_result.decoded_byte = 8'd0;
            o_result.byte_index   = (v_status == ST_BAD_LENGTH) ? 9'd0 : v_be;
            o_result.last_byte    = 1'b1;
        end else begin
            o_result.decoded_byte = v_byte;
            o_result.byte_index   = v_idx;
            o_result.last_byte    = v_last;
        end
        o_result.status = v_status;
        o_res_push      = fire && (v_have || v_status != ST_OK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving  <= 1'b0;
            r_nib_wait   <= 1'b0;
            r_upper      <= '0;
            r_emitted    <= '0;
            r_frame_size <= '0;
        end else if (fire) begin
            r_receiving  <= v_rx;
            r_nib_wait   <= v_nw;
            r_upper      <= v_up;
            r_emitted    <= v_be;
            r_frame_size <= v_fs;
        end
    end

endmodule

FILE: rtl/core/wmbus_mode_t_3of6_deframer.sv
// Channel   Direction  Handshake            Payload
// input     in         push / full          i_item   (frame_start, coded_byte)
// result    out        empty / pop          o_result (decoded_byte, byte_index,
//                                                     last_byte, status)
// config    in         i_cfg_we, no wait    i_cfg_index, i_cfg_data
//
// One coded byte is accepted in every cycle while the classification queue is not full; each gives at most one result.
// A result reaches the result ports through two registered queues: its byte's record is
// written into the classification queue, and the back part moves it into the result queue.
// Synchronous active-low reset restores the length limits and idles the deframer.
// A full result queue stalls the back part only; the front keeps accepting
// until the classification queue is full as well.
module wmbus_mode_t_3of6_deframer
    import wmt36_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  t_in_item   i_item,
    output logic       empty,
    input  logic       pop,
    output t_out_item  o_result,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    // The length limits are held here and read by the back part.
    t_limits   r_limits;

    t_sym_rec  front_rec;
    t_sym_rec  mid_rec;
    logic      mid_empty;
    logic      mid_pop;
    logic      in_accept;

    t_out_item back_result;
    logic      res_push;
    logic      res_full;

    assign in_accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.min_length <= RST_MIN_LENGTH;
            r_limits.max_length <= RST_MAX_LENGTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_LENGTH: r_limits.min_length <= i_cfg_data;
                CFG_MAX_LENGTH: r_limits.max_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The front part tracks symbol alignment and looks every symbol up in
    // the code table, whether or not a frame is being received.
    wmt36_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_item),
        .o_rec    (front_rec)
    );

    // The classification queue parts the front from the back.
    wmt36_fifo #(
        .t_item (t_sym_rec)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (front_rec),
        .o_full  (full),
        .i_pop   (mid_pop),
        .o_empty (mid_empty),
        .o_data  (mid_rec)
    );

    // The back part pairs nibbles into bytes, checks the length field and
    // counts bytes to the end of the frame.
    wmt36_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limits    (r_limits),
        .i_rec_valid (!mid_empty),
        .i_rec       (mid_rec),
        .o_rec_pop   (mid_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_result    (back_result)
    );

    // Results wait here until the consumer takes them; a stalled consumer holds up
    // the back part only once this queue is full.
    wmt36_fifo #(
        .t_item (t_out_item)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_result),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_result)
    );

endmodule
